// ===== design/ebc_pkg.sv =====
package ebc_pkg;

    typedef enum logic [2:0] {
        STEP_IDLE  = 3'd0,
        STEP_FETCH = 3'd1,
        STEP_CB    = 3'd2,
        STEP_OP0   = 3'd3,
        STEP_OP1   = 3'd4,
        STEP_OP2   = 3'd5,
        STEP_OP3   = 3'd6,
        STEP_SPARE = 3'd7
    } step_t;

    localparam logic [3:0] FLAG_Z = 4'b1000;
    localparam logic [3:0] FLAG_N = 4'b0100;
    localparam logic [3:0] FLAG_H = 4'b0010;
    localparam logic [3:0] FLAG_C = 4'b0001;

    localparam logic [7:0]  CB_PREFIX = 8'hcb;
    localparam logic [15:0] HIGH_PAGE = 16'hff00;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_INVALID = 2'd1;
    localparam logic [1:0] FAULT_HALT    = 2'd2;
    localparam logic [1:0] FAULT_STOP    = 2'd3;

    // architectural state of the core
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [3:0]  f;
        logic [15:0] pc;
        logic [15:0] sp;
        logic        ime;
        logic [15:0] op;
        step_t       step;
        logic        halted;
        logic [1:0]  stop_code;
    } cpu_state_t;

    // one bus request with status
    typedef struct packed {
        logic [15:0] bus_address;
        logic        bus_write;
        logic [7:0]  write_data;
        logic        instruction_done;
        logic [4:0]  instruction_cycles;
        logic [1:0]  fault;
        logic        interrupts_on;
    } bus_req_t;

endpackage

// ===== design/eight_bit_cpu_instruction_executor.sv =====
// bus-driven 8-bit cpu core executing a subset of the lr35902 instruction set
//
// channels: s_ carries one request per accepted item: action in s_tuser
// (0 start at start_address, 1 previous bus request complete) and the read
// byte in s_tdata. m_ carries the next bus request: address, write flag,
// write data, done flag, cycle count, fault code and interrupt enable.
// cfg_ is a separate write channel loading the 16-bit start address.
//
// latency: the result register is loaded at the edge that accepts the
// request, so the result can be taken at the following edge; the item is
// decoded and executed by combinational logic between the state registers
// and the output register. throughput: one item per cycle while results are
// taken, set by the single decode/execute pass.
//
// reset clears all architectural state; the core sits idle until a start
// request. if the receiver stalls the output register holds its request and
// s_tready falls only while a full result waits and is not being taken.
module eight_bit_cpu_instruction_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // read_data
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // bus_address, bus_write, write_data,
                                   // instruction_done, instruction_cycles,
                                   // fault, interrupts_on, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    ebc_pkg::cpu_state_t st_reg, st_next;
    ebc_pkg::bus_req_t   req, out_reg;
    logic [15:0] start_reg;
    logic [7:0]  opnd0_reg;
    logic [7:0]  opnd1_reg;
    logic        opnd0_we;
    logic [7:0]  opnd0_wd;
    logic        opnd1_we;
    logic [7:0]  opnd1_wd;
    logic        valid_reg;
    logic        s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~valid_reg | m_tready;
    assign s_acc     = s_tvalid & s_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {6'd0, out_reg.interrupts_on, out_reg.fault,
                        out_reg.instruction_cycles, out_reg.instruction_done,
                        out_reg.write_data, out_reg.bus_write, out_reg.bus_address};

    ebc_exec u_exec (
        .action        (s_tuser),
        .rd            (s_tdata),
        .start_address (start_reg),
        .st            (st_reg),
        .opnd0         (opnd0_reg),
        .opnd1         (opnd1_reg),
        .st_next       (st_next),
        .opnd0_we      (opnd0_we),
        .opnd0_wd      (opnd0_wd),
        .opnd1_we      (opnd1_we),
        .opnd1_wd      (opnd1_wd),
        .req           (req)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= '0;
            start_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) start_reg <= cfg_data;
            if (s_acc) begin
                st_reg    <= st_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload: operand latches and result register
    always_ff @(posedge aclk) begin
        if (s_acc && opnd0_we) opnd0_reg <= opnd0_wd;
        if (s_acc && opnd1_we) opnd1_reg <= opnd1_wd;
        if (s_acc) out_reg <= req;
    end

    // a done request never writes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> !m_tdata[16])
        else $error("opcode fetch issued as a write");

    // a stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a fault never comes with a done flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32:31] != ebc_pkg::FAULT_NONE |-> !m_tdata[25])
        else $error("fault with done");

endmodule

// ===== design/ebc_exec.sv =====
module ebc_exec (
    input  logic                   action,
    input  logic [7:0]             rd,
    input  logic [15:0]            start_address,
    input  ebc_pkg::cpu_state_t    st,
    input  logic [7:0]             opnd0,
    input  logic [7:0]             opnd1,
    output ebc_pkg::cpu_state_t    st_next,
    output logic                   opnd0_we,
    output logic [7:0]             opnd0_wd,
    output logic                   opnd1_we,
    output logic [7:0]             opnd1_wd,
    output ebc_pkg::bus_req_t      req
);

    logic [7:0]  o;
    logic [2:0]  hi, lo;
    logic [1:0]  pi;
    logic [15:0] hl, pc1, w, pairv;
    logic [2:0]  ph;
    logic        run;
    logic [7:0]  srcv, dstv, subv, res8;
    logic        take;

    function automatic logic [7:0] get_r(input ebc_pkg::cpu_state_t s, input logic [2:0] c);
        logic [7:0] v;
        case (c)
            3'd0: v = s.b;
            3'd1: v = s.c;
            3'd2: v = s.d;
            3'd3: v = s.e;
            3'd4: v = s.h;
            3'd5: v = s.l;
            3'd6: v = 8'd0;
            default: v = s.a;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] get_p(input ebc_pkg::cpu_state_t s, input logic [1:0] i);
        logic [15:0] v;
        case (i)
            2'd0: v = {s.b, s.c};
            2'd1: v = {s.d, s.e};
            2'd2: v = {s.h, s.l};
            default: v = s.sp;
        endcase
        return v;
    endfunction

    always_comb begin
        st_next  = st;
        opnd0_we = 1'b0;
        opnd0_wd = rd;
        opnd1_we = 1'b0;
        opnd1_wd = rd;
        req      = '0;
        req.bus_address = st.pc;
        req.fault = st.halted ? st.stop_code : ebc_pkg::FAULT_NONE;
        o = st.op[7:0];
        hi = o[5:3]; lo = o[2:0]; pi = o[5:4];
        hl = {st.h, st.l};
        pc1 = st.pc + 16'd1;
        w = {rd, opnd0};
        ph = 3'd0;
        run = 1'b0;
        srcv = 8'd0; dstv = 8'd0; subv = 8'd0; res8 = 8'd0;
        take = 1'b1;
        pairv = 16'd0;

        if (!action) begin
            st_next.halted = 1'b0;
            st_next.stop_code = ebc_pkg::FAULT_NONE;
            st_next.pc = start_address;
            st_next.step = ebc_pkg::STEP_FETCH;
            req.fault = ebc_pkg::FAULT_NONE;
            req.bus_address = start_address;
            req.instruction_done = 1'b1;
        end else if (st.halted || st.step == ebc_pkg::STEP_IDLE
                     || st.step == ebc_pkg::STEP_SPARE) begin
            // nothing pending
        end else if (st.step == ebc_pkg::STEP_FETCH) begin
            st_next.pc = pc1;
            if (rd == ebc_pkg::CB_PREFIX) begin
                st_next.op = {ebc_pkg::CB_PREFIX, 8'd0};
                st_next.step = ebc_pkg::STEP_CB;
                req.bus_address = pc1;
            end else begin
                st_next.op = {8'd0, rd};
                run = 1'b1;
            end
        end else if (st.step == ebc_pkg::STEP_CB) begin
            st_next.pc = pc1;
            st_next.op = {ebc_pkg::CB_PREFIX, rd};
            run = 1'b1;
        end else begin
            ph = 3'(st.step - ebc_pkg::STEP_CB);
            run = 1'b1;
        end

        if (run) begin
            // decode from the updated opcode and pc
            o = st_next.op[7:0];
            hi = o[5:3]; lo = o[2:0]; pi = o[5:4];
            hl = {st_next.h, st_next.l};
            pc1 = st_next.pc + 16'd1;
            st_next.step = ebc_pkg::STEP_FETCH;
            req.bus_write = 1'b0;
            req.write_data = 8'd0;
            req.instruction_done = 1'b1;
            // default finish uses the final pc, patched below
            if (st_next.op[15:8] == ebc_pkg::CB_PREFIX) begin
                srcv = get_r(st_next, lo);
                if (lo == 3'd6 || o < 8'h40 || o >= 8'hc0) begin
                    st_next.step = ebc_pkg::STEP_IDLE;
                    st_next.halted = 1'b1;
                    st_next.stop_code = ebc_pkg::FAULT_INVALID;
                    req.instruction_done = 1'b0;
                    req.fault = ebc_pkg::FAULT_INVALID;
                end else begin
                    req.instruction_cycles = 5'd8;
                    if (o < 8'h80) begin
                        st_next.f[3] = ~srcv[hi];
                        st_next.f[2] = 1'b0;
                        st_next.f[1] = 1'b1;
                    end else begin
                        res8 = srcv & ~(8'd1 << hi);
                        case (lo)
                            3'd0: st_next.b = res8;
                            3'd1: st_next.c = res8;
                            3'd2: st_next.d = res8;
                            3'd3: st_next.e = res8;
                            3'd4: st_next.h = res8;
                            3'd5: st_next.l = res8;
                            default: st_next.a = res8;
                        endcase
                    end
                end
            end else begin
                case (o)
                    8'h00: req.instruction_cycles = 5'd4;
                    8'h10, 8'h76: begin
                        st_next.step = ebc_pkg::STEP_IDLE;
                        st_next.halted = 1'b1;
                        st_next.stop_code = (o == 8'h10) ? ebc_pkg::FAULT_STOP
                                                         : ebc_pkg::FAULT_HALT;
                        req.fault = st_next.stop_code;
                        req.instruction_done = 1'b0;
                    end
                    8'hf3, 8'hfb: begin
                        st_next.ime = o[3];
                        req.instruction_cycles = 5'd4;
                    end
                    8'h03, 8'h13, 8'h23, 8'h33: begin
                        pairv = get_p(st_next, pi) + 16'd1;
                        case (pi)
                            2'd0: {st_next.b, st_next.c} = pairv;
                            2'd1: {st_next.d, st_next.e} = pairv;
                            2'd2: {st_next.h, st_next.l} = pairv;
                            default: st_next.sp = pairv;
                        endcase
                        req.instruction_cycles = 5'd8;
                    end
                    8'h01, 8'h11, 8'h21, 8'h31, 8'hc3, 8'hea, 8'hcd: begin
                        if (ph == 3'd0) begin
                            st_next.step = ebc_pkg::STEP_OP0;
                            req.instruction_done = 1'b0;
                        end else if (ph == 3'd1) begin
                            opnd0_we = 1'b1;
                            st_next.pc = pc1;
                            st_next.step = ebc_pkg::STEP_OP1;
                            req.instruction_done = 1'b0;
                        end else if (ph == 3'd2) begin
                            st_next.pc = pc1;
                            opnd1_we = 1'b1; // hold high operand byte
                            if (o == 8'hc3) begin
                                st_next.pc = w;
                                req.instruction_cycles = 5'd12;
                            end else if (o == 8'hea) begin
                                st_next.step = ebc_pkg::STEP_OP2;
                                req.instruction_done = 1'b0;
                                req.bus_write = 1'b1;
                                req.write_data = st_next.a;
                            end else if (o == 8'hcd) begin
                                st_next.sp = st.sp - 16'd1;
                                st_next.step = ebc_pkg::STEP_OP2;
                                req.instruction_done = 1'b0;
                                req.bus_write = 1'b1;
                                req.write_data = pc1[15:8];
                            end else begin
                                case (pi)
                                    2'd0: {st_next.b, st_next.c} = w;
                                    2'd1: {st_next.d, st_next.e} = w;
                                    2'd2: {st_next.h, st_next.l} = w;
                                    default: st_next.sp = w;
                                endcase
                                req.instruction_cycles = 5'd12;
                            end
                        end else if (o == 8'hcd && st.step == ebc_pkg::STEP_OP2) begin
                            st_next.sp = st.sp - 16'd1;
                            st_next.step = ebc_pkg::STEP_OP3;
                            req.instruction_done = 1'b0;
                            req.bus_write = 1'b1;
                            req.write_data = st.pc[7:0];
                        end else begin
                            if (o == 8'hcd) begin
                                st_next.pc = {opnd1, opnd0};
                                req.instruction_cycles = 5'd24;
                            end else begin
                                req.instruction_cycles = (o == 8'hea) ? 5'd16 : 5'd12;
                            end
                        end
                    end
                    8'hf0, 8'he0: begin
                        if (ph == 3'd0) begin
                            st_next.step = ebc_pkg::STEP_OP0;
                            req.instruction_done = 1'b0;
                        end else if (ph == 3'd1) begin
                            st_next.pc = pc1;
                            st_next.step = ebc_pkg::STEP_OP1;
                            req.instruction_done = 1'b0;
                            if (o == 8'he0) begin
                                req.bus_write = 1'b1;
                                req.write_data = st_next.a;
                            end
                        end else begin
                            if (o == 8'hf0) st_next.a = rd;
                            req.instruction_cycles = 5'd12;
                        end
                    end
                    8'h0a, 8'h1a, 8'h2a, 8'h3a, 8'h02, 8'h12, 8'h22, 8'h32: begin
                        if (ph == 3'd0) begin
                            st_next.step = ebc_pkg::STEP_OP0;
                            req.instruction_done = 1'b0;
                            req.bus_write = ~o[3];
                            req.write_data = o[3] ? 8'd0 : st_next.a;
                        end else begin
                            if (o[3]) st_next.a = rd;
                            if (pi == 2'd2) {st_next.h, st_next.l} = hl + 16'd1;
                            if (pi == 2'd3) {st_next.h, st_next.l} = hl - 16'd1;
                            req.instruction_cycles = 5'd8;
                        end
                    end
                    8'hc5, 8'hd5, 8'he5, 8'hf5: begin
                        if (ph < 3'd2) begin
                            case ({pi, ph[0]})
                                3'b000: srcv = st.b;
                                3'b001: srcv = st.c;
                                3'b010: srcv = st.d;
                                3'b011: srcv = st.e;
                                3'b100: srcv = st.h;
                                3'b101: srcv = st.l;
                                3'b110: srcv = st.a;
                                default: srcv = {st.f, 4'd0};
                            endcase
                            st_next.sp = st.sp - 16'd1;
                            st_next.step = ph[0] ? ebc_pkg::STEP_OP1 : ebc_pkg::STEP_OP0;
                            req.instruction_done = 1'b0;
                            req.bus_write = 1'b1;
                            req.write_data = srcv;
                        end else begin
                            req.instruction_cycles = 5'd16;
                        end
                    end
                    8'hc1, 8'hd1, 8'he1, 8'hf1, 8'hc9: begin
                        if (ph == 3'd0) begin
                            st_next.step = ebc_pkg::STEP_OP0;
                            req.instruction_done = 1'b0;
                        end else if (ph == 3'd1) begin
                            opnd0_we = 1'b1;
                            st_next.sp = st.sp + 16'd1;
                            st_next.step = ebc_pkg::STEP_OP1;
                            req.instruction_done = 1'b0;
                        end else begin
                            st_next.sp = st.sp + 16'd1;
                            if (o == 8'hc9) begin
                                st_next.pc = w;
                                req.instruction_cycles = 5'd16;
                            end else begin
                                case (pi)
                                    2'd0: {st_next.b, st_next.c} = w;
                                    2'd1: {st_next.d, st_next.e} = w;
                                    2'd2: {st_next.h, st_next.l} = w;
                                    default: begin
                                        st_next.a = rd;
                                        st_next.f = opnd0[7:4];
                                    end
                                endcase
                                req.instruction_cycles = 5'd12;
                            end
                        end
                    end
                    8'hb8, 8'h90, 8'hfe: begin
                        if (o == 8'hfe && ph == 3'd0) begin
                            st_next.step = ebc_pkg::STEP_OP0;
                            req.instruction_done = 1'b0;
                        end else begin
                            if (o == 8'hfe) st_next.pc = pc1;
                            subv = (o == 8'hfe) ? rd : st.b;
                            res8 = st.a - subv;
                            st_next.f = {res8 == 8'd0, 1'b1, st.a[3:0] < subv[3:0], st.a < subv};
                            if (o == 8'h90) st_next.a = res8;
                            req.instruction_cycles = 5'd4;
                        end
                    end
                    8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
                        case (o)
                            8'h20: take = ~st.f[3];
                            8'h28: take = st.f[3];
                            8'h30: take = ~st.f[0];
                            8'h38: take = st.f[0];
                            default: take = 1'b1;
                        endcase
                        if (ph == 3'd0) begin
                            if (!take) begin
                                st_next.pc = pc1;
                                req.instruction_cycles = 5'd8;
                            end else begin
                                st_next.step = ebc_pkg::STEP_OP0;
                                req.instruction_done = 1'b0;
                            end
                        end else begin
                            st_next.pc = pc1 + {{8{rd[7]}}, rd};
                            req.instruction_cycles = 5'd12;
                        end
                    end
                    default: begin
                        srcv = get_r(st_next, lo);
                        dstv = get_r(st_next, hi);
                        if (o[7:6] == 2'b00 && (lo == 3'd4 || lo == 3'd5 || lo == 3'd6)
                            && hi != 3'd6) begin
                            if (lo == 3'd6 && ph == 3'd0) begin
                                st_next.step = ebc_pkg::STEP_OP0;
                                req.instruction_done = 1'b0;
                            end else begin
                                if (lo == 3'd4) begin
                                    res8 = dstv + 8'd1;
                                    st_next.f[3:1] = {res8 == 8'd0, 1'b0, dstv[3:0] == 4'hf};
                                    req.instruction_cycles = 5'd4;
                                end else if (lo == 3'd5) begin
                                    res8 = dstv - 8'd1;
                                    st_next.f[3:1] = {res8 == 8'd0, 1'b1, dstv[3:0] == 4'h0};
                                    req.instruction_cycles = 5'd4;
                                end else begin
                                    st_next.pc = pc1;
                                    res8 = rd;
                                    req.instruction_cycles = 5'd8;
                                end
                                case (hi)
                                    3'd0: st_next.b = res8;
                                    3'd1: st_next.c = res8;
                                    3'd2: st_next.d = res8;
                                    3'd3: st_next.e = res8;
                                    3'd4: st_next.h = res8;
                                    3'd5: st_next.l = res8;
                                    default: st_next.a = res8;
                                endcase
                            end
                        end else if (o[7:6] == 2'b01) begin
                            if (lo == 3'd6 || hi == 3'd6) begin
                                if (ph == 3'd0) begin
                                    st_next.step = ebc_pkg::STEP_OP0;
                                    req.instruction_done = 1'b0;
                                    req.bus_write = (lo != 3'd6);
                                    req.write_data = (lo != 3'd6) ? srcv : 8'd0;
                                end else begin
                                    req.instruction_cycles = 5'd8;
                                end
                            end else begin
                                req.instruction_cycles = 5'd4;
                            end
                            if (hi != 3'd6 && !(lo == 3'd6 && ph == 3'd0)) begin
                                res8 = (lo == 3'd6) ? rd : srcv;
                                case (hi)
                                    3'd0: st_next.b = res8;
                                    3'd1: st_next.c = res8;
                                    3'd2: st_next.d = res8;
                                    3'd3: st_next.e = res8;
                                    3'd4: st_next.h = res8;
                                    3'd5: st_next.l = res8;
                                    default: st_next.a = res8;
                                endcase
                            end
                        end else if (o[7:3] == 5'b10101 && lo != 3'd6) begin
                            res8 = st.a ^ srcv;
                            st_next.a = res8;
                            st_next.f = {res8 == 8'd0, 3'b000};
                            req.instruction_cycles = 5'd4;
                        end else begin
                            st_next.step = ebc_pkg::STEP_IDLE;
                            st_next.halted = 1'b1;
                            st_next.stop_code = ebc_pkg::FAULT_INVALID;
                            req.instruction_done = 1'b0;
                            req.fault = ebc_pkg::FAULT_INVALID;
                        end
                    end
                endcase
            end

            // address of the next access
            if (req.instruction_done || st_next.halted) begin
                req.bus_address = st_next.pc;
            end else begin
                case (o)
                    8'hea: req.bus_address = (ph == 3'd2) ? w : st_next.pc;
                    8'hcd: req.bus_address = (ph >= 3'd2) ? st_next.sp : st_next.pc;
                    8'hf0, 8'he0:
                        req.bus_address = (ph == 3'd1) ? (ebc_pkg::HIGH_PAGE | {8'd0, rd})
                                                       : st_next.pc;
                    8'h0a, 8'h1a, 8'h02, 8'h12: req.bus_address = get_p(st_next, pi);
                    8'h2a, 8'h3a, 8'h22, 8'h32: req.bus_address = hl;
                    8'hc5, 8'hd5, 8'he5, 8'hf5,
                    8'hc1, 8'hd1, 8'he1, 8'hf1, 8'hc9: req.bus_address = st_next.sp;
                    default:
                        req.bus_address = (o[7:6] == 2'b01) ? hl : st_next.pc;
                endcase
            end
        end
        req.interrupts_on = st_next.ime;
    end

endmodule

// ===== sim/tb_eight_bit_cpu_instruction_executor.sv =====
`timescale 1ns / 1ps

module tb_eight_bit_cpu_instruction_executor;

    // request codes on the input channel
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DONE  = 1'b1;

    // opcodes decoded by name
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_STOP     = 8'h10;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_DI       = 8'hf3;
    localparam logic [7:0] OP_EI       = 8'hfb;
    localparam logic [7:0] OP_JP       = 8'hc3;
    localparam logic [7:0] OP_CALL     = 8'hcd;
    localparam logic [7:0] OP_RET      = 8'hc9;
    localparam logic [7:0] OP_ST_A16   = 8'hea;
    localparam logic [7:0] OP_LDH_LD   = 8'hf0;
    localparam logic [7:0] OP_LDH_ST   = 8'he0;
    localparam logic [7:0] OP_CP_B     = 8'hb8;
    localparam logic [7:0] OP_SUB_B    = 8'h90;
    localparam logic [7:0] OP_CP_D8    = 8'hfe;
    localparam logic [7:0] OP_JR       = 8'h18;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_JR_Z     = 8'h28;
    localparam logic [7:0] OP_JR_NC    = 8'h30;
    localparam logic [7:0] OP_JR_C     = 8'h38;
    localparam logic [7:0] OP_LD_A_D8  = 8'h3e;
    localparam logic [7:0] OP_DEC_B    = 8'h05;
    localparam logic [7:0] OP_BAD      = 8'hd3;
    localparam logic [7:0] OP_LD_HL_NN = 8'h21;
    localparam logic [7:0] OP_LD_SP_NN = 8'h31;
    localparam logic [7:0] OP_PUSH_AF  = 8'hf5;
    localparam logic [7:0] OP_POP_AF   = 8'hf1;
    localparam logic [7:0] OP_LD_HLI_A = 8'h22;
    localparam logic [7:0] OP_LD_A_HLD = 8'h3a;
    localparam logic [7:0] OP_XOR_A    = 8'haf;
    localparam logic [7:0] OP_INC_HL   = 8'h23;
    localparam logic [7:0] CB_BIT7_A   = 8'h7f;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 135;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // read_data
    logic        s_tuser = 1'b0;  // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // bus_address, bus_write, write_data,
                                  // instruction_done, instruction_cycles,
                                  // fault, interrupts_on, zero fill
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    eight_bit_cpu_instruction_executor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the core's architectural state
    logic [15:0]        start_pc;
    logic [7:0]         acc;
    logic [7:0]         gpr [6];
    logic [3:0]         flg;
    logic [15:0]        pc;
    logic [15:0]        sp;
    logic               ime;
    logic [15:0]        opcode;
    ebc_pkg::step_t     step;
    logic [7:0]         opnd [2];
    logic               halted;
    logic [1:0]         stop_code;
    ebc_pkg::bus_req_t  nxt_req;

    ebc_pkg::bus_req_t  pending_reqs[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // ------------------------------------------------------------------
    // predictor of the next bus request
    // ------------------------------------------------------------------
    function automatic void put_flag(logic [3:0] mask, logic v);
        flg = v ? (flg | mask) : (flg & ~mask);
    endfunction

    function automatic logic [7:0] reg_rd(logic [2:0] c);
        if (c == 3'd7) return acc;
        if (c == 3'd6) return 8'h00;
        return gpr[c];
    endfunction

    function automatic void reg_wr(logic [2:0] c, logic [7:0] v);
        if (c == 3'd7) acc = v;
        else if (c < 3'd6) gpr[c] = v;
    endfunction

    function automatic logic [15:0] pair_rd(logic [1:0] i);
        if (i == 2'd3) return sp;
        return {gpr[2*i], gpr[2*i+1]};
    endfunction

    function automatic void pair_wr(logic [1:0] i, logic [15:0] v);
        if (i == 2'd3) sp = v;
        else begin
            gpr[2*i]   = v[15:8];
            gpr[2*i+1] = v[7:0];
        end
    endfunction

    function automatic void issue_read(int ph, logic [15:0] a);
        nxt_req.bus_address = a;
        nxt_req.bus_write   = 1'b0;
        nxt_req.write_data  = 8'h00;
        step = ebc_pkg::step_t'(3 + ph);
    endfunction

    function automatic void issue_write(int ph, logic [15:0] a, logic [7:0] v);
        nxt_req.bus_address = a;
        nxt_req.bus_write   = 1'b1;
        nxt_req.write_data  = v;
        step = ebc_pkg::step_t'(3 + ph);
    endfunction

    function automatic void retire(logic [4:0] cyc);
        nxt_req.bus_address        = pc;
        nxt_req.bus_write          = 1'b0;
        nxt_req.write_data         = 8'h00;
        nxt_req.instruction_done   = 1'b1;
        nxt_req.instruction_cycles = cyc;
        step = ebc_pkg::STEP_FETCH;
    endfunction

    function automatic void stop_core(logic [1:0] code);
        halted    = 1'b1;
        stop_code = code;
        step      = ebc_pkg::STEP_IDLE;
        nxt_req.bus_address        = pc;
        nxt_req.bus_write          = 1'b0;
        nxt_req.write_data         = 8'h00;
        nxt_req.instruction_done   = 1'b0;
        nxt_req.instruction_cycles = 5'd0;
        nxt_req.fault              = code;
    endfunction

    function automatic void compare_a(logic [7:0] v, logic keep);
        logic [7:0] res;
        res = acc - v;
        put_flag(ebc_pkg::FLAG_N, 1'b1);
        put_flag(ebc_pkg::FLAG_H, acc[3:0] < v[3:0]);
        put_flag(ebc_pkg::FLAG_C, acc < v);
        put_flag(ebc_pkg::FLAG_Z, res == 8'h00);
        if (keep) acc = res;
    endfunction

    function automatic void exec_cb(logic [7:0] low);
        logic [2:0] r;
        logic [2:0] b;
        logic [7:0] v;
        r = low[2:0];
        b = low[5:3];
        v = reg_rd(r);
        if (r == 3'd6 || low < 8'h40 || low >= 8'hc0) begin
            stop_core(ebc_pkg::FAULT_INVALID);
            return;
        end
        if (low < 8'h80) begin
            put_flag(ebc_pkg::FLAG_Z, !v[b]);
            put_flag(ebc_pkg::FLAG_N, 1'b0);
            put_flag(ebc_pkg::FLAG_H, 1'b1);
        end else begin
            v[b] = 1'b0;
            reg_wr(r, v);
        end
        retire(5'd8);
    endfunction

    function automatic void exec_op(int ph, logic [7:0] d);
        logic [7:0]  o;
        logic [2:0]  hi;
        logic [2:0]  lo;
        logic [1:0]  pi;
        logic [15:0] hl;
        logic [15:0] w;
        logic [7:0]  v;
        logic        take;
        o  = opcode[7:0];
        hi = o[5:3];
        lo = o[2:0];
        pi = o[5:4];
        hl = pair_rd(2'd2);
        if (opcode[15:8] == ebc_pkg::CB_PREFIX) begin
            exec_cb(o);
            return;
        end
        case (o)
            OP_NOP: begin retire(5'd4); return; end
            OP_STOP: begin stop_core(ebc_pkg::FAULT_STOP); return; end
            OP_HALT: begin stop_core(ebc_pkg::FAULT_HALT); return; end
            OP_DI: begin ime = 1'b0; retire(5'd4); return; end
            OP_EI: begin ime = 1'b1; retire(5'd4); return; end
            8'h03, 8'h13, OP_INC_HL, 8'h33: begin
                pair_wr(pi, pair_rd(pi) + 16'd1);
                retire(5'd8);
                return;
            end
            8'h01, 8'h11, OP_LD_HL_NN, OP_LD_SP_NN, OP_JP, OP_ST_A16, OP_CALL: begin
                if (ph == 0) begin issue_read(0, pc); return; end
                if (ph == 1) begin
                    opnd[0] = d;
                    pc = pc + 16'd1;
                    issue_read(1, pc);
                    return;
                end
                if (ph == 2) begin
                    opnd[1] = d;
                    pc = pc + 16'd1;
                    w = {opnd[1], opnd[0]};
                    if (o == OP_JP) begin pc = w; retire(5'd12); return; end
                    if (o == OP_ST_A16) begin issue_write(2, w, acc); return; end
                    if (o == OP_CALL) begin
                        sp = sp - 16'd1;
                        issue_write(2, sp, pc[15:8]);
                        return;
                    end
                    pair_wr(pi, w);
                    retire(5'd12);
                    return;
                end
                if (o == OP_CALL && ph == 3) begin
                    sp = sp - 16'd1;
                    issue_write(3, sp, pc[7:0]);
                    return;
                end
                if (o == OP_CALL) begin
                    pc = {opnd[1], opnd[0]};
                    retire(5'd24);
                    return;
                end
                retire(o == OP_ST_A16 ? 5'd16 : 5'd12);
                return;
            end
            OP_LDH_LD, OP_LDH_ST: begin
                if (ph == 0) begin issue_read(0, pc); return; end
                if (ph == 1) begin
                    pc = pc + 16'd1;
                    if (o == OP_LDH_LD) issue_read(1, ebc_pkg::HIGH_PAGE | {8'h00, d});
                    else issue_write(1, ebc_pkg::HIGH_PAGE | {8'h00, d}, acc);
                    return;
                end
                if (o == OP_LDH_LD) acc = d;
                retire(5'd12);
                return;
            end
            8'h0a, 8'h1a, 8'h2a, OP_LD_A_HLD: begin
                if (ph == 0) begin
                    issue_read(0, o < 8'h20 ? pair_rd(pi) : hl);
                    return;
                end
                acc = d;
                if (o == 8'h2a) pair_wr(2'd2, hl + 16'd1);
                if (o == OP_LD_A_HLD) pair_wr(2'd2, hl - 16'd1);
                retire(5'd8);
                return;
            end
            8'h02, 8'h12, OP_LD_HLI_A, 8'h32: begin
                if (ph == 0) begin
                    issue_write(0, o < 8'h20 ? pair_rd(pi) : hl, acc);
                    return;
                end
                if (o == OP_LD_HLI_A) pair_wr(2'd2, hl + 16'd1);
                if (o == 8'h32) pair_wr(2'd2, hl - 16'd1);
                retire(5'd8);
                return;
            end
            8'hc5, 8'hd5, 8'he5, OP_PUSH_AF: begin
                if (ph < 2) begin
                    if (pi == 2'd3) v = (ph == 0) ? acc : {flg, 4'h0};
                    else v = gpr[2*pi + ph];
                    sp = sp - 16'd1;
                    issue_write(ph, sp, v);
                    return;
                end
                retire(5'd16);
                return;
            end
            8'hc1, 8'hd1, 8'he1, OP_POP_AF, OP_RET: begin
                if (ph == 0) begin issue_read(0, sp); return; end
                if (ph == 1) begin
                    opnd[0] = d;
                    sp = sp + 16'd1;
                    issue_read(1, sp);
                    return;
                end
                sp = sp + 16'd1;
                if (o == OP_RET) begin
                    pc = {d, opnd[0]};
                    retire(5'd16);
                    return;
                end
                if (pi == 2'd3) begin
                    acc = d;
                    flg = opnd[0][7:4];
                end else pair_wr(pi, {d, opnd[0]});
                retire(5'd12);
                return;
            end
            OP_CP_B: begin compare_a(gpr[0], 1'b0); retire(5'd4); return; end
            OP_SUB_B: begin compare_a(gpr[0], 1'b1); retire(5'd4); return; end
            OP_CP_D8: begin
                if (ph == 0) begin issue_read(0, pc); return; end
                pc = pc + 16'd1;
                compare_a(d, 1'b0);
                retire(5'd4);
                return;
            end
            OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
                if (ph == 0) begin
                    take = 1'b1;
                    if (o == OP_JR_NZ) take = (flg & ebc_pkg::FLAG_Z) == 4'h0;
                    if (o == OP_JR_Z)  take = (flg & ebc_pkg::FLAG_Z) != 4'h0;
                    if (o == OP_JR_NC) take = (flg & ebc_pkg::FLAG_C) == 4'h0;
                    if (o == OP_JR_C)  take = (flg & ebc_pkg::FLAG_C) != 4'h0;
                    if (!take) begin
                        pc = pc + 16'd1;
                        retire(5'd8);
                        return;
                    end
                    issue_read(0, pc);
                    return;
                end
                pc = pc + 16'd1;
                pc = pc + {{8{d[7]}}, d};
                retire(5'd12);
                return;
            end
            default: ;
        endcase

        // register families
        if ((o & 8'hc7) == 8'h04 && hi != 3'd6) begin
            v = reg_rd(hi);
            put_flag(ebc_pkg::FLAG_N, 1'b0);
            put_flag(ebc_pkg::FLAG_H, v[3:0] == 4'hf);
            v = v + 8'd1;
            put_flag(ebc_pkg::FLAG_Z, v == 8'h00);
            reg_wr(hi, v);
            retire(5'd4);
            return;
        end
        if ((o & 8'hc7) == 8'h05 && hi != 3'd6) begin
            v = reg_rd(hi);
            put_flag(ebc_pkg::FLAG_N, 1'b1);
            put_flag(ebc_pkg::FLAG_H, v[3:0] == 4'h0);
            v = v - 8'd1;
            put_flag(ebc_pkg::FLAG_Z, v == 8'h00);
            reg_wr(hi, v);
            retire(5'd4);
            return;
        end
        if ((o & 8'hc7) == 8'h06 && hi != 3'd6) begin
            if (ph == 0) begin issue_read(0, pc); return; end
            pc = pc + 16'd1;
            reg_wr(hi, d);
            retire(5'd8);
            return;
        end
        if (o >= 8'h40 && o < 8'h80) begin
            if (lo == 3'd6) begin
                if (ph == 0) begin issue_read(0, hl); return; end
                reg_wr(hi, d);
                retire(5'd8);
                return;
            end
            if (hi == 3'd6) begin
                if (ph == 0) begin issue_write(0, hl, reg_rd(lo)); return; end
                retire(5'd8);
                return;
            end
            reg_wr(hi, reg_rd(lo));
            retire(5'd4);
            return;
        end
        if (o >= 8'ha8 && o < 8'hb0 && lo != 3'd6) begin
            acc = acc ^ reg_rd(lo);
            put_flag(ebc_pkg::FLAG_Z, acc == 8'h00);
            put_flag(ebc_pkg::FLAG_N, 1'b0);
            put_flag(ebc_pkg::FLAG_H, 1'b0);
            put_flag(ebc_pkg::FLAG_C, 1'b0);
            retire(5'd4);
            return;
        end
        stop_core(ebc_pkg::FAULT_INVALID);
    endfunction

    // advance the shadow core by one accepted request
    function automatic ebc_pkg::bus_req_t predict_bus_req(logic act, logic [7:0] d);
        nxt_req = '0;
        nxt_req.bus_address = pc;
        nxt_req.fault = halted ? stop_code : ebc_pkg::FAULT_NONE;
        if (act == ACT_START) begin
            halted = 1'b0;
            stop_code = ebc_pkg::FAULT_NONE;
            nxt_req.fault = ebc_pkg::FAULT_NONE;
            pc = start_pc;
            retire(5'd0);
        end else if (halted || step == ebc_pkg::STEP_IDLE
                     || step == ebc_pkg::STEP_SPARE) begin
            // nothing outstanding, core just repeats its idle read
        end else if (step == ebc_pkg::STEP_FETCH) begin
            pc = pc + 16'd1;
            if (d == ebc_pkg::CB_PREFIX) begin
                opcode = {ebc_pkg::CB_PREFIX, 8'h00};
                nxt_req.bus_address = pc;
                step = ebc_pkg::STEP_CB;
            end else begin
                opcode = {8'h00, d};
                exec_op(0, 8'h00);
            end
        end else if (step == ebc_pkg::STEP_CB) begin
            pc = pc + 16'd1;
            opcode = {ebc_pkg::CB_PREFIX, d};
            exec_op(0, 8'h00);
        end else begin
            exec_op(int'(step) - 2, d);
        end
        nxt_req.interrupts_on = ime;
        return nxt_req;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d requests outstanding", $time, pending_reqs.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_start_addr(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_pc = v;
    endtask

    // one request on the input channel; typed expectation overrides the
    // predicted one when given, the shadow state advances in both cases
    task automatic send_req(logic act, logic [7:0] d, logic typed,
                            ebc_pkg::bus_req_t exp_req);
        ebc_pkg::bus_req_t p;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        p = predict_bus_req(act, d);
        pending_reqs.push_back(typed ? exp_req : p);
    endtask

    task automatic drain(int extra);
        s_tvalid <= 1'b0;
        while (pending_reqs.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // realistic opcode mix for the fetch step
    function automatic logic [7:0] pick_opcode();
        logic [7:0] legal [] = '{OP_NOP, OP_DI, OP_EI, OP_JP, OP_CALL, OP_RET, OP_ST_A16,
            OP_LDH_LD, OP_LDH_ST, OP_CP_B, OP_SUB_B, OP_CP_D8, OP_JR, OP_JR_NZ, OP_JR_Z,
            OP_JR_NC, OP_JR_C, 8'h01, 8'h11, OP_LD_HL_NN, OP_LD_SP_NN, 8'h03, 8'h13,
            OP_INC_HL, 8'h33, 8'h0a, 8'h1a, 8'h2a, OP_LD_A_HLD, 8'h02, 8'h12,
            OP_LD_HLI_A, 8'h32, 8'hc5, 8'hd5, 8'he5, OP_PUSH_AF, 8'hc1, 8'hd1, 8'he1,
            OP_POP_AF, ebc_pkg::CB_PREFIX, OP_STOP, OP_XOR_A};
        int k;
        k = $urandom_range(99);
        if (k < 12) return 8'(($urandom_range(7) << 3) | 4 | $urandom_range(2));
        if (k < 24) return 8'($urandom_range(8'h40, 8'h7f));
        if (k < 28) return 8'($urandom_range(8'ha8, 8'haf));
        if (k < 33) return 8'($urandom_range(255));
        return legal[$urandom_range(legal.size() - 1)];
    endfunction

    task automatic random_req();
        logic [7:0] d;
        d = 8'($urandom_range(255));
        if (halted || step == ebc_pkg::STEP_IDLE) begin
            if ($urandom_range(9) < 8) send_req(ACT_START, d, 1'b0, '0);
            else send_req(ACT_DONE, d, 1'b0, '0);
        end else if ($urandom_range(99) < 2) begin
            // restart in the middle of an instruction
            send_req(ACT_START, d, 1'b0, '0);
        end else begin
            if (step == ebc_pkg::STEP_FETCH) d = pick_opcode();
            else if (step == ebc_pkg::STEP_CB && $urandom_range(4) != 0)
                d = 8'($urandom_range(8'h40, 8'hbf));
            send_req(ACT_DONE, d, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        ebc_pkg::bus_req_t got;
        ebc_pkg::bus_req_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.bus_address        = m_tdata[15:0];
            got.bus_write          = m_tdata[16];
            got.write_data         = m_tdata[24:17];
            got.instruction_done   = m_tdata[25];
            got.instruction_cycles = m_tdata[30:26];
            got.fault              = m_tdata[32:31];
            got.interrupts_on      = m_tdata[33];
            if (pending_reqs.size() == 0) begin
                $display("%0t unexpected bus request %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_reqs.pop_front();
                check_field("bus_address", want.bus_address, got.bus_address);
                check_field("bus_write", 16'(want.bus_write), 16'(got.bus_write));
                check_field("write_data", 16'(want.write_data), 16'(got.write_data));
                check_field("instruction_done", 16'(want.instruction_done),
                            16'(got.instruction_done));
                check_field("instruction_cycles", 16'(want.instruction_cycles),
                            16'(got.instruction_cycles));
                check_field("fault", 16'(want.fault), 16'(got.fault));
                check_field("interrupts_on", 16'(want.interrupts_on),
                            16'(got.interrupts_on));
            end
        end
    end

    // ------------------------------------------------------------------
    // directed sequence: a short program walking through the special cases
    // ------------------------------------------------------------------
    typedef struct {
        logic              act;
        logic [7:0]        d;
        logic              typed;
        ebc_pkg::bus_req_t exp_req;
    } stim_row_t;

    stim_row_t plan [] = '{
        // completion with nothing outstanding after reset: idle read of 0
        '{ACT_DONE,  8'h5a, 1'b1,
          '{16'h0000, 1'b0, 8'h00, 1'b0, 5'd0, ebc_pkg::FAULT_NONE, 1'b0}},
        // start at address 0: opcode fetch, no cycles yet
        '{ACT_START, 8'h00, 1'b1,
          '{16'h0000, 1'b0, 8'h00, 1'b1, 5'd0, ebc_pkg::FAULT_NONE, 1'b0}},
        // nop retires and fetches the next opcode
        '{ACT_DONE,  OP_NOP, 1'b1,
          '{16'h0001, 1'b0, 8'h00, 1'b1, 5'd4, ebc_pkg::FAULT_NONE, 1'b0}},
        '{ACT_DONE,  OP_LD_A_D8, 1'b0, '0},
        '{ACT_DONE,  8'hff, 1'b0, '0},
        '{ACT_DONE,  OP_EI, 1'b0, '0},
        '{ACT_DONE,  ebc_pkg::CB_PREFIX, 1'b0, '0},
        '{ACT_DONE,  CB_BIT7_A, 1'b0, '0},
        '{ACT_DONE,  OP_ST_A16, 1'b0, '0},
        '{ACT_DONE,  8'h00, 1'b0, '0},
        '{ACT_DONE,  8'hff, 1'b0, '0},
        // write completion, data byte ignored
        '{ACT_DONE,  8'hff, 1'b0, '0},
        '{ACT_DONE,  OP_DEC_B, 1'b0, '0},
        '{ACT_DONE,  OP_SUB_B, 1'b0, '0},
        // zero flag now set: conditional jump not taken skips its offset
        '{ACT_DONE,  OP_JR_NZ, 1'b0, '0},
        '{ACT_DONE,  OP_DI, 1'b0, '0},
        '{ACT_DONE,  OP_HALT, 1'b0, '0},
        '{ACT_DONE,  8'h00, 1'b0, '0},
        '{ACT_START, 8'hff, 1'b0, '0},
        '{ACT_DONE,  OP_BAD, 1'b0, '0},
        '{ACT_START, 8'h00, 1'b0, '0},
        '{ACT_DONE,  OP_STOP, 1'b0, '0}
    };

    initial begin
        int send_mode [4];
        int recv_mode [4];
        logic [15:0] addr_mode [4];

        send_mode = '{0, 87, 0, 38};
        recv_mode = '{0, 0, 87, 38};
        start_pc = '0; acc = '0; flg = '0; pc = '0; sp = '0; ime = 1'b0;
        opcode = '0; step = ebc_pkg::STEP_IDLE; halted = 1'b0;
        stop_code = ebc_pkg::FAULT_NONE;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (opnd[i]) opnd[i] = '0;
        addr_mode = '{16'hffff, 16'h0000, 16'($urandom_range(16'hffff)), 16'hff80};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_start_addr(16'h0000);
        foreach (plan[i]) send_req(plan[i].act, plan[i].d, plan[i].typed, plan[i].exp_req);
        drain(4);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mode[ph];
            recv_stall_pct = recv_mode[ph];
            write_start_addr(addr_mode[ph]);
            send_req(ACT_START, 8'($urandom_range(255)), 1'b0, '0);
            repeat (PHASE_ITEMS) random_req();
            drain(4);
        end

        recv_stall_pct = 0;
        drain(10);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ebc_pkg.sv
design/ebc_exec.sv
design/eight_bit_cpu_instruction_executor.sv
sim/tb_eight_bit_cpu_instruction_executor.sv
